/* rtl/core/trm_pkg.sv */
// trm_pkg: widths, types and constants shared by the traffic rate meter.
// No dependencies; used by trm_cnt, traffic_rate_meter_ema and the test bench.
package trm_pkg;

    localparam int BYTE_W  = 16;   // message byte count
    localparam int TIME_W  = 48;   // microsecond time stamp
    localparam int TOTAL_W = 48;   // running byte total
    localparam int CNT_W   = 32;   // period byte and message counts
    localparam int RATE_W  = 40;   // byte rate, Q32.8
    localparam int MRATE_W = 32;   // message rate, Q24.8
    localparam int SAMP_W  = 11;   // averaging sample count
    localparam int USEC_W  = 20;   // width of one million
    localparam int PROD_W  = CNT_W + USEC_W;

    localparam logic [USEC_W-1:0]  USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [SAMP_W-1:0]  SAMP_RESET   = SAMP_W'(10);
    localparam logic [RATE_W-1:0]  RATE_MAX     = '1;
    localparam logic [MRATE_W-1:0] MRATE_MAX    = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX      = '1;

    typedef logic [TIME_W-1:0] t_time;

    // traffic counters as seen by the sequencer
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [CNT_W-1:0]   period_bytes;
        logic [CNT_W-1:0]   period_msgs;
    } t_cnt_status;

endpackage

/* rtl/core/trm_cnt.sv */
// trm_cnt: saturating byte total and per-period byte and message counters.
// Depends on trm_pkg.
module trm_cnt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_msg,
    input  logic [trm_pkg::BYTE_W-1:0]   i_byte_count,
    input  logic                         i_clear,
    output trm_pkg::t_cnt_status         o_status
);

    logic [trm_pkg::TOTAL_W-1:0] r_total;
    logic [trm_pkg::CNT_W-1:0]   r_pbytes;
    logic [trm_pkg::CNT_W-1:0]   r_pmsgs;
    logic [trm_pkg::TOTAL_W:0]   w_total_sum;
    logic [trm_pkg::CNT_W:0]     w_pbytes_sum;

    assign w_total_sum  = {1'b0, r_total} + (trm_pkg::TOTAL_W+1)'(i_byte_count);
    assign w_pbytes_sum = {1'b0, r_pbytes} + (trm_pkg::CNT_W+1)'(i_byte_count);

    // accumulate on message items, clear the period at each measurement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_pbytes <= '0;
            r_pmsgs  <= '0;
        end else if (i_clear) begin
            r_pbytes <= '0;
            r_pmsgs  <= '0;
        end else if (i_msg) begin
            r_total  <= w_total_sum[trm_pkg::TOTAL_W] ? trm_pkg::TOTAL_MAX
                                                      : w_total_sum[trm_pkg::TOTAL_W-1:0];
            r_pbytes <= w_pbytes_sum[trm_pkg::CNT_W] ? trm_pkg::CNT_MAX
                                                     : w_pbytes_sum[trm_pkg::CNT_W-1:0];
            if (r_pmsgs != trm_pkg::CNT_MAX) begin
                r_pmsgs <= r_pmsgs + 1'b1;
            end
        end
    end

    assign o_status.total        = r_total;
    assign o_status.period_bytes = r_pbytes;
    assign o_status.period_msgs  = r_pmsgs;

endmodule

/* rtl/core/trm_div.sv */
// trm_div: bit-serial restoring divider, one quotient bit per cycle.
// No dependencies; standalone logic.
module trm_div #(
    parameter int NW = 60,
    parameter int DW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic [DW+1:0] w_diff;
    logic          w_ge;

    // shift the next numerator bit into the partial remainder and try a subtract
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge    = ~w_diff[DW+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: numerator shifts out the top while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/core/traffic_rate_meter_ema.sv */
// Traffic rate meter with exponential moving averages. A message item (mode 0)
// adds its bytes to the saturating total and the period counts and is taken with
// no result. A measurement item (mode 1) yields one result: byte and message
// rates over the elapsed time in unsigned fixed point with FRAC_BITS fraction
// bits, and their running averages over avg_samples samples. In a measurement,
// four divisions (two rates, two averages) run in turn on one bit-serial
// divider that retires one quotient bit per cycle. Rates skipped for zero
// counts or zero elapsed time save one division each. A finished result sits
// in an output register, so new items are taken while it waits.
//
// traffic_rate_meter_ema: top level, sequencer, averages and output register.
// Depends on trm_pkg, trm_cnt and trm_div.
module traffic_rate_meter_ema #(
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [trm_pkg::SAMP_W-1:0]     i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [trm_pkg::BYTE_W-1:0]     i_byte_count,
    input  logic [trm_pkg::TIME_W-1:0]     i_time_us,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [trm_pkg::RATE_W-1:0]     o_rate_last,
    output logic [trm_pkg::RATE_W-1:0]     o_rate_avg,
    output logic [trm_pkg::MRATE_W-1:0]    o_msg_rate,
    output logic [trm_pkg::MRATE_W-1:0]    o_msg_rate_avg,
    output logic [trm_pkg::TOTAL_W-1:0]    o_bytes_total,
    output logic [trm_pkg::CNT_W-1:0]      o_last_period_bytes
);

    localparam int NW      = trm_pkg::PROD_W + FRAC_BITS;
    localparam int RATE_W  = trm_pkg::RATE_W;
    localparam int MRATE_W = trm_pkg::MRATE_W;
    localparam int SAMP_W  = trm_pkg::SAMP_W;
    localparam int PROD_W  = trm_pkg::PROD_W;
    localparam int TIME_W  = trm_pkg::TIME_W;
    localparam int CNT_W   = trm_pkg::CNT_W;
    localparam int EMUL_W  = RATE_W + SAMP_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RMUL   = 3'd1;
    localparam logic [2:0] ST_RSTART = 3'd2;
    localparam logic [2:0] ST_RWAIT  = 3'd3;
    localparam logic [2:0] ST_EMUL   = 3'd4;
    localparam logic [2:0] ST_ESTART = 3'd5;
    localparam logic [2:0] ST_EWAIT  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic                      r_sel;          // 0: byte rate, 1: message rate
    logic [SAMP_W-1:0]         r_avg_samples;
    trm_pkg::t_time            r_last_time;
    trm_pkg::t_time            r_now;
    trm_pkg::t_time            r_elapsed;
    logic [PROD_W-1:0]         r_prod;
    logic [RATE_W-1:0]         r_addend;
    logic [RATE_W-1:0]         r_brate;
    logic [MRATE_W-1:0]        r_mrate;
    logic [RATE_W-1:0]         r_avg_b;
    logic [MRATE_W-1:0]        r_avg_m;
    logic [CNT_W-1:0]          r_latched;
    logic                      r_out_valid;
    logic [RATE_W-1:0]         r_o_rate_last;
    logic [RATE_W-1:0]         r_o_rate_avg;
    logic [MRATE_W-1:0]        r_o_msg_rate;
    logic [MRATE_W-1:0]        r_o_msg_rate_avg;
    logic [trm_pkg::TOTAL_W-1:0] r_o_bytes_total;
    logic [CNT_W-1:0]          r_o_last_period;

    trm_pkg::t_cnt_status      w_cnt;
    logic                      w_in_acc;
    logic                      w_out_load;
    logic [CNT_W-1:0]          w_count;
    logic                      w_rate_zero;
    logic                      w_rate_skip;
    logic [PROD_W-1:0]         w_rmul;
    logic [SAMP_W-1:0]         w_n;
    logic [SAMP_W-1:0]         w_nm1;
    logic [RATE_W-1:0]         w_avg_old;
    logic [RATE_W-1:0]         w_rate;
    logic [RATE_W-1:0]         w_seed;
    logic [EMUL_W-1:0]         w_emul;
    logic                      w_div_start;
    logic [NW-1:0]             w_div_num;
    logic [TIME_W-1:0]         w_div_den;
    logic                      w_div_busy;
    logic                      w_div_done;
    logic [NW-1:0]             w_quo;
    logic [RATE_W-1:0]         w_rate_q;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // traffic counters
    trm_cnt u_cnt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg        (w_in_acc && !i_mode),
        .i_byte_count (i_byte_count),
        .i_clear      (w_out_load),
        .o_status     (w_cnt)
    );

    // rate operands: the message rate is zero when the period had no bytes
    assign w_count     = r_sel ? w_cnt.period_msgs : w_cnt.period_bytes;
    assign w_rate_zero = (w_count == '0) || (r_sel && (w_cnt.period_bytes == '0));
    assign w_rate_skip = w_rate_zero || (r_elapsed == '0);
    assign w_rmul      = w_count * trm_pkg::USEC_PER_SEC;

    // average operands: n of zero acts as one, a zero average takes the new rate
    assign w_n       = (r_avg_samples == '0) ? SAMP_W'(1) : r_avg_samples;
    assign w_nm1     = w_n - 1'b1;
    assign w_avg_old = r_sel ? RATE_W'(r_avg_m) : r_avg_b;
    assign w_rate    = r_sel ? RATE_W'(r_mrate) : r_brate;
    assign w_seed    = (w_avg_old == '0) ? w_rate : w_avg_old;
    assign w_emul    = w_seed * w_nm1;

    // shared divider
    assign w_div_start = ((r_state == ST_RSTART) && !w_rate_skip) || (r_state == ST_ESTART);
    assign w_div_num   = (r_state == ST_ESTART) ? NW'(r_prod + PROD_W'(r_addend))
                                                : (NW'(r_prod) << FRAC_BITS);
    assign w_div_den   = (r_state == ST_ESTART) ? TIME_W'(w_n) : r_elapsed;

    trm_div #(
        .NW (NW),
        .DW (TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // saturate the rate quotient to the width of the rate being computed
    always_comb begin
        if (r_sel) begin
            w_rate_q = (|w_quo[NW-1:MRATE_W]) ? RATE_W'(trm_pkg::MRATE_MAX)
                                              : RATE_W'(w_quo[MRATE_W-1:0]);
        end else begin
            w_rate_q = (|w_quo[NW-1:RATE_W]) ? trm_pkg::RATE_MAX : w_quo[RATE_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_mode) begin
                    n_state = ST_RMUL;
                end
            end
            ST_RMUL:   n_state = ST_RSTART;
            ST_RSTART: begin
                if (!w_rate_skip) begin
                    n_state = ST_RWAIT;
                end else begin
                    n_state = r_sel ? ST_EMUL : ST_RMUL;
                end
            end
            ST_RWAIT: begin
                if (w_div_done) begin
                    n_state = r_sel ? ST_EMUL : ST_RMUL;
                end
            end
            ST_EMUL:   n_state = ST_ESTART;
            ST_ESTART: n_state = ST_EWAIT;
            ST_EWAIT: begin
                if (w_div_done) begin
                    n_state = r_sel ? ST_DONE : ST_EMUL;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sel         <= 1'b0;
            r_avg_samples <= trm_pkg::SAMP_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_avg_samples <= i_cfg_data;
            end
            // byte pass then message pass, once for rates and once for averages
            if ((r_state == ST_RSTART && w_rate_skip) || (r_state == ST_RWAIT && w_div_done)
                || (r_state == ST_EWAIT && w_div_done)) begin
                r_sel <= ~r_sel;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // measurement state and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_avg_b     <= '0;
            r_avg_m     <= '0;
            r_latched   <= '0;
        end else begin
            if (w_in_acc && i_mode) begin
                r_now     <= i_time_us;
                r_elapsed <= i_time_us - r_last_time;
            end
            if (r_state == ST_RMUL) begin
                r_prod <= w_rmul;
            end
            if (r_state == ST_EMUL) begin
                r_prod   <= PROD_W'(w_emul);
                r_addend <= w_rate;
            end
            // rate results: skipped divisions give zero or the saturated maximum
            if (r_state == ST_RSTART && w_rate_skip) begin
                if (r_sel) begin
                    r_mrate <= w_rate_zero ? '0 : trm_pkg::MRATE_MAX;
                end else begin
                    r_brate <= w_rate_zero ? '0 : trm_pkg::RATE_MAX;
                end
            end
            if (r_state == ST_RWAIT && w_div_done) begin
                if (r_sel) begin
                    r_mrate <= w_rate_q[MRATE_W-1:0];
                end else begin
                    r_brate <= w_rate_q;
                end
            end
            // averages never exceed the larger of old average and new rate
            if (r_state == ST_EWAIT && w_div_done) begin
                if (r_sel) begin
                    r_avg_m <= w_quo[MRATE_W-1:0];
                end else begin
                    r_avg_b <= w_quo[RATE_W-1:0];
                end
            end
            if (w_out_load) begin
                r_last_time <= r_now;
                if (w_cnt.period_bytes != '0) begin
                    r_latched <= w_cnt.period_bytes;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_rate_last    <= r_brate;
            r_o_rate_avg     <= r_avg_b;
            r_o_msg_rate     <= r_mrate;
            r_o_msg_rate_avg <= r_avg_m;
            r_o_bytes_total  <= w_cnt.total;
            r_o_last_period  <= (w_cnt.period_bytes != '0) ? w_cnt.period_bytes : r_latched;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_rate_last         = r_o_rate_last;
    assign o_rate_avg          = r_o_rate_avg;
    assign o_msg_rate          = r_o_msg_rate;
    assign o_msg_rate_avg      = r_o_msg_rate_avg;
    assign o_bytes_total       = r_o_bytes_total;
    assign o_last_period_bytes = r_o_last_period;

    // checks
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_measure_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_mode) |=> (r_state == ST_RMUL))
        else $error("measurement item did not start the sequence");

    a_period_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (w_cnt.period_bytes == '0) && (w_cnt.period_msgs == '0))
        else $error("period counters not cleared after a result");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result shown outside the final step");

    a_div_wait_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == ST_RWAIT) || (r_state == ST_EWAIT))
        else $error("divider busy outside a wait step");

endmodule

/* test/traffic_rate_meter_ema_test.sv */
`timescale 1ns / 100ps
// traffic_rate_meter_ema_test: self-checking bench for the traffic rate meter.
// Feeds message and measurement items, predicts every result and compares them.
// Depends on trm_pkg and traffic_rate_meter_ema.
module traffic_rate_meter_ema_test;

    localparam int BYTE_W  = trm_pkg::BYTE_W;
    localparam int TIME_W  = trm_pkg::TIME_W;
    localparam int TOTAL_W = trm_pkg::TOTAL_W;
    localparam int CNT_W   = trm_pkg::CNT_W;
    localparam int RATE_W  = trm_pkg::RATE_W;
    localparam int MRATE_W = trm_pkg::MRATE_W;
    localparam int SAMP_W  = trm_pkg::SAMP_W;

    localparam int FRAC        = 8;
    localparam int SETTLE      = 300;      // one full measurement plus margin
    localparam int CYCLE_CAP   = 3000000;
    localparam int PHASE_ITEMS = 130;
    localparam int REPORT_MAX  = 10;

    typedef enum logic {
        MODE_MSG     = 1'b0,
        MODE_MEASURE = 1'b1
    } t_meter_mode;

    typedef enum int {
        READY_ALWAYS,
        READY_EVERY_N,
        READY_HALF,
        READY_MOSTLY
    } t_ready_style;

    typedef struct packed {
        t_meter_mode       mode;
        logic [BYTE_W-1:0] nbytes;
        trm_pkg::t_time    stamp;
    } t_meter_item;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_last;
        logic [RATE_W-1:0]  rate_avg;
        logic [MRATE_W-1:0] msg_rate;
        logic [MRATE_W-1:0] msg_rate_avg;
        logic [TOTAL_W-1:0] bytes_total;
        logic [CNT_W-1:0]   last_period_bytes;
    } t_meter_report;

    // DUT inputs, all known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [SAMP_W-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               i_mode = 1'b0;
    logic [BYTE_W-1:0]  i_byte_count = '0;
    logic [TIME_W-1:0]  i_time_us = '0;
    logic               i_out_ready = 1'b0;

    // DUT outputs
    logic               o_in_ready;
    logic               o_out_valid;
    logic [RATE_W-1:0]  o_rate_last;
    logic [RATE_W-1:0]  o_rate_avg;
    logic [MRATE_W-1:0] o_msg_rate;
    logic [MRATE_W-1:0] o_msg_rate_avg;
    logic [TOTAL_W-1:0] o_bytes_total;
    logic [CNT_W-1:0]   o_last_period_bytes;

    // predicted meter state
    logic [SAMP_W-1:0]  samples_q = trm_pkg::SAMP_RESET;
    logic [TOTAL_W-1:0] bytes_total_q = '0;
    logic [CNT_W-1:0]   period_bytes_q = '0;
    logic [CNT_W-1:0]   period_msgs_q = '0;
    trm_pkg::t_time     prev_stamp_q = '0;
    logic [RATE_W-1:0]  byte_avg_q = '0;
    logic [MRATE_W-1:0] msg_avg_q = '0;
    logic [CNT_W-1:0]   held_bytes_q = '0;

    t_meter_item    traffic_q[$];
    t_meter_report  pending_reports[$];
    t_meter_item    cur_item;
    t_meter_report  want;
    trm_pkg::t_time clock_now = '0;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    // sender burst state
    int            burst_left = 0;
    int            gap_left = 0;
    int            gap_roll;

    // receiver stall state
    t_ready_style  stall_style = READY_ALWAYS;
    int            stall_left = 0;
    int            stall_span = 2;
    int            stall_tick = 0;

    traffic_rate_meter_ema #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_byte_count       (i_byte_count),
        .i_time_us          (i_time_us),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_rate_last        (o_rate_last),
        .o_rate_avg         (o_rate_avg),
        .o_msg_rate         (o_msg_rate),
        .o_msg_rate_avg     (o_msg_rate_avg),
        .o_bytes_total      (o_bytes_total),
        .o_last_period_bytes(o_last_period_bytes)
    );

    always #5 i_clk = ~i_clk;

    // count * 1e6 * 2^FRAC / span, clipped; zero span pins a nonzero count to the top
    function automatic logic [63:0] scaled_rate(input logic [CNT_W-1:0] count,
                                                input trm_pkg::t_time span,
                                                input logic [63:0] ceiling);
        logic [63:0] num;
        logic [63:0] quot;
        if (count == '0)
            return '0;
        if (span == '0)
            return ceiling;
        num = 64'(count);
        num = (num * 64'd1000000) << FRAC;
        quot = num / {16'd0, span};
        return (quot > ceiling) ? ceiling : quot;
    endfunction

    // exponential average, seeded with the new rate while still zero
    function automatic logic [63:0] ema_update(input logic [63:0] avg, input logic [63:0] rate,
                                               input logic [63:0] n);
        logic [63:0] seed;
        seed = (avg == '0) ? rate : avg;
        return (seed * (n - 64'd1) + rate) / n;
    endfunction

    // advance the predicted state by one accepted item
    task automatic account_item(input t_meter_item it);
        logic [TOTAL_W:0] total_sum;
        logic [CNT_W:0]   period_sum;
        trm_pkg::t_time   span;
        logic [63:0]      n;
        logic [63:0]      brate;
        logic [63:0]      mrate;
        logic [63:0]      avg;
        t_meter_report    rep;
        if (it.mode == MODE_MSG) begin
            total_sum = {1'b0, bytes_total_q} + (TOTAL_W+1)'(it.nbytes);
            bytes_total_q = total_sum[TOTAL_W] ? trm_pkg::TOTAL_MAX : total_sum[TOTAL_W-1:0];
            period_sum = {1'b0, period_bytes_q} + (CNT_W+1)'(it.nbytes);
            period_bytes_q = period_sum[CNT_W] ? trm_pkg::CNT_MAX : period_sum[CNT_W-1:0];
            if (period_msgs_q != trm_pkg::CNT_MAX)
                period_msgs_q = period_msgs_q + 1'b1;
        end else begin
            span = it.stamp - prev_stamp_q;
            n = (samples_q == '0) ? 64'd1 : {53'd0, samples_q};
            brate = scaled_rate(period_bytes_q, span, {24'd0, trm_pkg::RATE_MAX});
            mrate = '0;
            if (period_bytes_q != '0) begin
                mrate = scaled_rate(period_msgs_q, span, {32'd0, trm_pkg::MRATE_MAX});
                held_bytes_q = period_bytes_q;
            end
            avg = ema_update({24'd0, byte_avg_q}, brate, n);
            byte_avg_q = avg[RATE_W-1:0];
            avg = ema_update({32'd0, msg_avg_q}, mrate, n);
            msg_avg_q = avg[MRATE_W-1:0];
            prev_stamp_q = it.stamp;
            period_bytes_q = '0;
            period_msgs_q = '0;
            rep.rate_last = brate[RATE_W-1:0];
            rep.rate_avg = byte_avg_q;
            rep.msg_rate = mrate[MRATE_W-1:0];
            rep.msg_rate_avg = msg_avg_q;
            rep.bytes_total = bytes_total_q;
            rep.last_period_bytes = held_bytes_q;
            pending_reports.push_back(rep);
        end
    endtask

    task automatic check_field(input string label, input logic [63:0] got,
                               input logic [63:0] expd);
        if (got !== expd) begin
            if (mismatch_count < REPORT_MAX)
                $display("mismatch on %s: expected %0d, got %0d", label, expd, got);
            mismatch_count++;
        end
    endtask

    function automatic trm_pkg::t_time rand48();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[TIME_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] pick_bytes();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return '0;
        if (roll < 35)
            return '1;
        if (roll < 60)
            return BYTE_W'($urandom_range(1, 255));
        return BYTE_W'($urandom_range(0, 65535));
    endfunction

    // message items carry a random time stamp that the block must ignore
    task automatic push_msg(input logic [BYTE_W-1:0] nbytes);
        t_meter_item it;
        it.mode = MODE_MSG;
        it.nbytes = nbytes;
        it.stamp = rand48();
        traffic_q.push_back(it);
    endtask

    // measurement items carry a random byte count that the block must ignore
    task automatic push_measure(input trm_pkg::t_time stamp);
        t_meter_item it;
        it.mode = MODE_MEASURE;
        it.nbytes = BYTE_W'($urandom_range(0, 65535));
        it.stamp = stamp;
        clock_now = stamp;
        traffic_q.push_back(it);
    endtask

    // periods of random length, each closed by a measurement
    task automatic gen_traffic(input int n_items);
        int             made;
        int             k;
        int             roll;
        trm_pkg::t_time delta;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                k = 0;
            else if (roll < 75)
                k = $urandom_range(1, 6);
            else
                k = $urandom_range(7, 40);
            repeat (k) push_msg(pick_bytes());
            roll = $urandom_range(0, 99);
            if (roll < 8)
                delta = '0;
            else if (roll < 25)
                delta = TIME_W'($urandom_range(1, 16));
            else if (roll < 60)
                delta = TIME_W'($urandom_range(17, 2000000));
            else if (roll < 85)
                delta = {16'd0, $urandom};
            else
                delta = rand48();
            push_measure(clock_now + delta);
            made += k + 1;
        end
    endtask

    // wait for all items to go in and all results to come out, then let it settle
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (traffic_q.size() != 0 || i_in_valid || pending_reports.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_samples(input logic [SAMP_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        samples_q = value;
    endtask

    // driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                account_item(cur_item);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (traffic_q.size() != 0) begin
                    cur_item = traffic_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= cur_item.mode;
                    i_byte_count <= cur_item.nbytes;
                    i_time_us <= cur_item.stamp;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_roll = $urandom_range(0, 99);
                        if (gap_roll < 25)
                            gap_left = 0;
                        else if (gap_roll < 70)
                            gap_left = $urandom_range(1, 4);
                        else if (gap_roll < 93)
                            gap_left = $urandom_range(5, 40);
                        else
                            gap_left = $urandom_range(41, 300);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest prediction, stall on a pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("result with no expectation: rate_last %0d", o_rate_last);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("rate_last", 64'(o_rate_last), 64'(want.rate_last));
                check_field("rate_avg", 64'(o_rate_avg), 64'(want.rate_avg));
                check_field("msg_rate", 64'(o_msg_rate), 64'(want.msg_rate));
                check_field("msg_rate_avg", 64'(o_msg_rate_avg), 64'(want.msg_rate_avg));
                check_field("bytes_total", 64'(o_bytes_total), 64'(want.bytes_total));
                check_field("last_period_bytes", 64'(o_last_period_bytes),
                            64'(want.last_period_bytes));
            end
        end
        if (stall_left == 0) begin
            stall_style = t_ready_style'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 400);
            stall_span = $urandom_range(2, 8);
        end else begin
            stall_left--;
        end
        stall_tick++;
        unique case (stall_style)
            READY_ALWAYS:  i_out_ready <= 1'b1;
            READY_EVERY_N: i_out_ready <= (stall_tick % stall_span) == 0;
            READY_HALF:    i_out_ready <= 1'($urandom_range(0, 1));
            default:       i_out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int cfg_plan[6];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty period with no elapsed time
        push_measure('0);
        // messages without bytes: rates stay zero, latched bytes kept
        push_msg('0);
        push_msg('0);
        push_measure(48'd100);
        // bytes but no elapsed time: both rates saturate
        push_msg('1);
        push_measure(48'd100);
        // one microsecond elapsed
        push_msg(16'd1);
        push_measure(48'd101);
        // long period ending at the top of the time range
        push_msg('1);
        push_msg('1);
        push_msg('1);
        push_measure('1);
        // time wraps past zero, then goes backwards
        push_msg(16'd12345);
        push_measure(48'd5);
        push_msg(16'd7);
        push_measure(48'd3);
        // empty period after traffic: averages decay toward zero
        push_measure(48'd1000003);

        cfg_plan = '{1, 1024, 0, 2047, $urandom_range(2, 1023), $urandom_range(1, 1024)};
        foreach (cfg_plan[p]) begin
            wait_drained();
            write_samples(SAMP_W'(cfg_plan[p]));
            gen_traffic(PHASE_ITEMS);
        end
        wait_drained();

        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/trm_pkg.sv
rtl/core/trm_cnt.sv
rtl/core/trm_div.sv
rtl/core/traffic_rate_meter_ema.sv
test/traffic_rate_meter_ema_test.sv
